// File: src/r2i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to I420 converter package
// Shared constants, register indexes and the BT.601 Q16 color math.
// ----------------------------------------------------------------------------
package r2i_pkg;

  localparam int MAX_WIDTH_DEF = 2048;

  localparam int PIX_W  = 8;
  localparam int SUM_W  = 9;
  localparam int CFG_W  = 12;
  localparam int ROW_W  = 11;
  localparam int ACC_W  = 26;

  localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  localparam logic [ACC_W-1:0] CY_R  = 26'd16843;
  localparam logic [ACC_W-1:0] CY_G  = 26'd33030;
  localparam logic [ACC_W-1:0] CY_B  = 26'd6423;
  localparam logic [ACC_W-1:0] CU_R  = 26'd9699;
  localparam logic [ACC_W-1:0] CU_G  = 26'd19071;
  localparam logic [ACC_W-1:0] CU_B  = 26'd28770;
  localparam logic [ACC_W-1:0] CV_R  = 26'd28770;
  localparam logic [ACC_W-1:0] CV_G  = 26'd24117;
  localparam logic [ACC_W-1:0] CV_B  = 26'd4653;
  localparam logic [ACC_W-1:0] Y_OFS = 26'd1048576;
  localparam logic [ACC_W-1:0] C_OFS = 26'd8388608;

  function automatic logic [PIX_W-1:0] clamp_q16(input logic signed [ACC_W-1:0] acc);
    logic [PIX_W-1:0] res;
    if (acc < 0) begin
      res = '0;
    end else if (acc[ACC_W-2]) begin
      res = 8'd255;
    end else begin
      res = acc[23:16];
    end
    return res;
  endfunction

  function automatic logic [ACC_W-1:0] ext(input logic [PIX_W-1:0] x);
    return {{(ACC_W-PIX_W){1'b0}}, x};
  endfunction

  function automatic logic [PIX_W-1:0] calc_luma(input logic [PIX_W-1:0] r,
                                                 input logic [PIX_W-1:0] g,
                                                 input logic [PIX_W-1:0] b);
    logic [ACC_W-1:0] acc;
    acc = CY_R * ext(r) + CY_G * ext(g) + CY_B * ext(b) + Y_OFS;
    return clamp_q16($signed(acc));
  endfunction

  function automatic logic [PIX_W-1:0] calc_u(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic signed [ACC_W-1:0] acc;
    acc = $signed(CU_B * ext(b) + C_OFS) - $signed(CU_R * ext(r))
        - $signed(CU_G * ext(g));
    return clamp_q16(acc);
  endfunction

  function automatic logic [PIX_W-1:0] calc_v(input logic [PIX_W-1:0] r,
                                              input logic [PIX_W-1:0] g,
                                              input logic [PIX_W-1:0] b);
    logic signed [ACC_W-1:0] acc;
    acc = $signed(CV_R * ext(r) + C_OFS) - $signed(CV_G * ext(g))
        - $signed(CV_B * ext(b));
    return clamp_q16(acc);
  endfunction

endpackage

// File: src/rgb_to_i420_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to I420 converter
// BT.601 studio-range conversion of a raster RGB stream to Y with 2x2 chroma.
// ----------------------------------------------------------------------------
// Pixels enter on the in_ stream one request at a time in raster order and
// leave on the out_ stream, one result per pixel. Each result carries the
// pixel's luma; on the bottom-right pixel of each 2x2 block out_tuser is set
// and U and V of that block are valid, otherwise they read zero. out_tlast
// marks the last pixel of the frame. Frame width and height come from the
// cfg_ write port; a write restarts the frame at the top-left pixel.
// A request accepted at one edge is loaded into the input register at that
// edge, together with the line store read, and moves on to the result
// register once that register is empty or its result is being taken.
// When the receiver stalls, the result register holds and the input
// register still takes one more pixel before in_tready drops. Reset sets
// the frame size to 640 by 480 and empties both registers; the line store
// needs no clearing because each odd row reads what its even row wrote.
// ----------------------------------------------------------------------------
module rgb_to_i420_converter #(
  parameter int MAX_WIDTH = r2i_pkg::MAX_WIDTH_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [23:0]               in_tdata,   // red, green, blue
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [23:0]               out_tdata,  // luma, chroma_u, chroma_v
  output logic [0:0]                out_tuser,  // chroma_valid
  output logic                      out_tlast,
  input  logic                      cfg_we,
  input  logic [0:0]                cfg_index,
  input  logic [r2i_pkg::CFG_W-1:0] cfg_wdata
);

  localparam int LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
  localparam int AW   = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  localparam int CW   = ($clog2(MAX_WIDTH) > AW + 1) ? $clog2(MAX_WIDTH) : AW + 1;
  localparam int CAPB = $clog2(MAX_WIDTH + 1);
  localparam int EW   = ((CAPB > r2i_pkg::CFG_W) ? CAPB : r2i_pkg::CFG_W) + 1;
  localparam logic [EW-1:0] WCAP = EW'(MAX_WIDTH) & ~EW'(1);
  localparam int PW   = r2i_pkg::PIX_W;
  localparam int SW   = r2i_pkg::SUM_W;
  localparam int RW   = r2i_pkg::ROW_W;

  logic [r2i_pkg::CFG_W-1:0] width_r, height_r;
  logic [CW-1:0]             col_r;
  logic [RW-1:0]             row_r;
  logic [3*PW-1:0]           left_r;

  logic                      s1_valid_r, s1_chroma_r, s1_last_r;
  logic [3*PW-1:0]           s1_pix_r;
  logic [3*SW-1:0]           s1_sum_r;

  logic                      out_valid_r, out_cv_r, out_last_r;
  logic [PW-1:0]             out_luma_r, out_u_r, out_v_r;

  logic                      in_accept, s1_adv;
  logic [EW-1:0]             w_eff, w_mask, col_inc;
  logic [r2i_pkg::CFG_W-1:0] h_eff, h_mask;
  logic [r2i_pkg::CFG_W:0]   row_inc;
  logic                      col_last, row_last;
  logic [3*SW-1:0]           pair_sum, ram_rdata;
  logic [PW-1:0]             avg_r, avg_g, avg_b, luma_c;
  logic [SW:0]               tot_r, tot_g, tot_b;

  always_comb begin
    w_mask = EW'(width_r) & ~EW'(1);
    if (w_mask < EW'(2)) begin
      w_eff = EW'(2);
    end else if (w_mask > WCAP) begin
      w_eff = WCAP;
    end else begin
      w_eff = w_mask;
    end
    h_mask = height_r & ~r2i_pkg::CFG_W'(1);
    h_eff  = (h_mask < r2i_pkg::CFG_W'(2)) ? r2i_pkg::CFG_W'(2) : h_mask;
  end

  assign col_inc  = EW'(col_r) + EW'(1);
  assign row_inc  = (r2i_pkg::CFG_W + 1)'(row_r) + (r2i_pkg::CFG_W + 1)'(1);
  assign col_last = (col_inc >= w_eff);
  assign row_last = (row_inc >= {1'b0, h_eff});

  assign s1_adv    = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  assign pair_sum = {SW'(in_tdata[23:16]) + SW'(left_r[23:16]),
                     SW'(in_tdata[15:8])  + SW'(left_r[15:8]),
                     SW'(in_tdata[7:0])   + SW'(left_r[7:0])};

  r2i_ram #(
    .WIDTH (3 * SW),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_accept && col_r[0] && !row_r[0]),
    .waddr (col_r[AW:1]),
    .wdata (pair_sum),
    .re    (in_accept && col_r[0] && row_r[0]),
    .raddr (col_r[AW:1]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= r2i_pkg::FRAME_WIDTH_RST;
      height_r <= r2i_pkg::FRAME_HEIGHT_RST;
      col_r    <= '0;
      row_r    <= '0;
      left_r   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        r2i_pkg::REG_FRAME_WIDTH:  width_r  <= cfg_wdata;
        r2i_pkg::REG_FRAME_HEIGHT: height_r <= cfg_wdata;
        default: ;
      endcase
      col_r <= '0;
      row_r <= '0;
    end else if (in_accept) begin
      if (!col_r[0]) begin
        left_r <= in_tdata;
      end
      if (col_last) begin
        col_r <= '0;
        row_r <= row_last ? '0 : RW'(row_inc);
      end else begin
        col_r <= CW'(col_inc);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_pix_r    <= in_tdata;
      s1_sum_r    <= pair_sum;
      s1_chroma_r <= col_r[0] && row_r[0];
      s1_last_r   <= col_last && row_last;
    end
  end

  assign tot_r = (SW + 1)'(s1_sum_r[SW-1:0])      + (SW + 1)'(ram_rdata[SW-1:0]);
  assign tot_g = (SW + 1)'(s1_sum_r[2*SW-1:SW])   + (SW + 1)'(ram_rdata[2*SW-1:SW]);
  assign tot_b = (SW + 1)'(s1_sum_r[3*SW-1:2*SW]) + (SW + 1)'(ram_rdata[3*SW-1:2*SW]);
  assign avg_r = tot_r[SW:2];
  assign avg_g = tot_g[SW:2];
  assign avg_b = tot_b[SW:2];
  assign luma_c = r2i_pkg::calc_luma(s1_pix_r[7:0], s1_pix_r[15:8], s1_pix_r[23:16]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      out_luma_r <= luma_c;
      out_cv_r   <= s1_chroma_r;
      out_last_r <= s1_last_r;
      out_u_r    <= s1_chroma_r ? r2i_pkg::calc_u(avg_r, avg_g, avg_b) : '0;
      out_v_r    <= s1_chroma_r ? r2i_pkg::calc_v(avg_r, avg_g, avg_b) : '0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_v_r, out_u_r, out_luma_r};
  assign out_tuser  = out_cv_r;
  assign out_tlast  = out_last_r;

  // The input register can only refuse a request while it holds a pixel.
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> s1_valid_r)
    else $error("in_tready low with an empty input register");

  // The line store read data must not move while its pixel waits.
  a_line_data_held: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> $stable(ram_rdata))
    else $error("line store data changed under a stalled pixel");

  a_col_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    EW'(col_r) < w_eff)
    else $error("column count outside the frame width");

  // The last pixel of a frame always closes a 2x2 block.
  a_last_has_chroma: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[0])
    else $error("frame end without chroma");

endmodule

// File: src/r2i_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module r2i_ram #(
  parameter int WIDTH = 27,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to I420 converter testbench
// Streams RGB frames of many sizes through the converter and checks every
// result against a bit-exact BT.601 Q16 predictor with its own line store.
// ----------------------------------------------------------------------------
module tb;

  localparam int LINE_MAX    = 2048;
  localparam int LINE_DEPTH  = LINE_MAX / 2;
  localparam int CYCLE_LIMIT = 500000;

  localparam longint K_YR = 16843;
  localparam longint K_YG = 33030;
  localparam longint K_YB = 6423;
  localparam longint K_UR = 9699;
  localparam longint K_UG = 19071;
  localparam longint K_UB = 28770;
  localparam longint K_VR = 28770;
  localparam longint K_VG = 24117;
  localparam longint K_VB = 4653;

  typedef struct packed {
    logic [7:0] luma;
    logic       chroma_valid;
    logic [7:0] chroma_u;
    logic [7:0] chroma_v;
    logic       frame_end;
  } yuv_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [11:0] cfg_wdata;

  yuv_t        expected_yuv[$];
  int          errors;
  int          hold_len;
  bit          steady;
  int unsigned cycle_count;

  logic [11:0] pred_width;
  logic [11:0] pred_height;
  logic [26:0] pair_line[LINE_DEPTH];
  logic [23:0] left_px;
  int          col_pos;
  int          row_pos;

  rgb_to_i420_converter #(
    .MAX_WIDTH(LINE_MAX)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic logic [7:0] q16_clamp(input longint acc);
    longint q;
    if (acc < 0) return 8'd0;
    q = acc >>> 16;
    return (q > 255) ? 8'd255 : q[7:0];
  endfunction

  function automatic int eff_width(input logic [11:0] v);
    int w;
    w = int'(v & 12'hFFE);
    if (w < 2) w = 2;
    if (w > LINE_MAX) w = LINE_MAX;
    return w;
  endfunction

  function automatic int eff_height(input logic [11:0] v);
    int h;
    h = int'(v & 12'hFFE);
    return (h < 2) ? 2 : h;
  endfunction

  function automatic yuv_t convert_pixel(input logic [7:0] r, input logic [7:0] g,
                                         input logic [7:0] b);
    yuv_t        res;
    int          w;
    int          h;
    int          idx;
    int          sr;
    int          sg;
    int          sb;
    longint      ar;
    longint      ag;
    longint      ab;
    logic [26:0] e;
    w = eff_width(pred_width);
    h = eff_height(pred_height);
    idx = (col_pos >> 1) % LINE_DEPTH;
    res = '0;
    res.luma = q16_clamp(K_YR * r + K_YG * g + K_YB * b + (longint'(16) << 16));
    if ((col_pos & 1) == 0) begin
      left_px = {b, g, r};
    end else begin
      sr = int'(r) + int'(left_px[7:0]);
      sg = int'(g) + int'(left_px[15:8]);
      sb = int'(b) + int'(left_px[23:16]);
      if ((row_pos & 1) == 0) begin
        pair_line[idx] = {sb[8:0], sg[8:0], sr[8:0]};
      end else begin
        e = pair_line[idx];
        ar = (sr + int'(e[8:0])) >> 2;
        ag = (sg + int'(e[17:9])) >> 2;
        ab = (sb + int'(e[26:18])) >> 2;
        res.chroma_u = q16_clamp(-K_UR * ar - K_UG * ag + K_UB * ab + (longint'(128) << 16));
        res.chroma_v = q16_clamp(K_VR * ar - K_VG * ag - K_VB * ab + (longint'(128) << 16));
        res.chroma_valid = 1'b1;
      end
    end
    res.frame_end = (col_pos + 1 >= w) && (row_pos + 1 >= h);
    if (col_pos + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1 >= h) ? 0 : ((row_pos + 1) & 32'h7FF);
    end else begin
      col_pos = col_pos + 1;
    end
    return res;
  endfunction

  function automatic logic [7:0] rand_channel();
    int p;
    p = $urandom_range(99);
    if (p < 12) return 8'h00;
    if (p < 24) return 8'hFF;
    return 8'($urandom_range(255));
  endfunction

  task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
    if (!steady && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {b, g, r};
    do @(posedge clk); while (!in_tready);
    expected_yuv.push_back(convert_pixel(r, g, b));
  endtask

  task automatic send_random_pixels(input int count);
    for (int i = 0; i < count; i++) begin
      send_pixel(rand_channel(), rand_channel(), rand_channel());
    end
  endtask

  task automatic wait_drain();
    in_tvalid <= 1'b0;
    while (expected_yuv.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [11:0] val);
    wait_drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == r2i_pkg::REG_FRAME_WIDTH) begin
      pred_width = val;
    end else begin
      pred_height = val;
    end
    col_pos = 0;
    row_pos = 0;
  endtask

  task automatic set_frame(input logic [11:0] w, input logic [11:0] h);
    write_reg(r2i_pkg::REG_FRAME_WIDTH, w);
    write_reg(r2i_pkg::REG_FRAME_HEIGHT, h);
  endtask

  task automatic test_reset_size();
    send_random_pixels(642);
  endtask

  task automatic test_colors();
    logic [23:0] colors[16];
    colors = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
               24'h000000, 24'h000000, 24'h000000, 24'h000000,
               24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFFFF,
               24'hFFFF00, 24'h00FFFF, 24'hFF00FF, 24'h808080};
    set_frame(12'd2, 12'd2);
    foreach (colors[i]) begin
      send_pixel(colors[i][23:16], colors[i][15:8], colors[i][7:0]);
    end
  endtask

  task automatic test_size_rounding();
    set_frame(12'd3, 12'd1);
    send_random_pixels(4);
    set_frame(12'd0, 12'd3);
    send_random_pixels(4);
  endtask

  task automatic test_restart();
    set_frame(12'd6, 12'd4);
    send_random_pixels(9);
    write_reg(r2i_pkg::REG_FRAME_HEIGHT, 12'd4);
    send_random_pixels(24);
  endtask

  task automatic test_line_extremes();
    set_frame(12'd2048, 12'd1);
    send_random_pixels(40);
    set_frame(12'd4095, 12'd0);
    send_random_pixels(40);
    set_frame(12'd2, 12'd2048);
    send_random_pixels(40);
    set_frame(12'd2, 12'd4095);
    send_random_pixels(20);
  endtask

  task automatic test_backpressure();
    set_frame(12'd8, 12'd4);
    hold_len = 300;
    send_random_pixels(64);
    wait_drain();
    send_random_pixels(32);
  endtask

  task automatic test_steady_stream();
    set_frame(12'd16, 12'd4);
    steady = 1'b1;
    send_random_pixels(192);
    steady = 1'b0;
  endtask

  task automatic test_random_frames();
    int total;
    int p;
    int which;
    int frame;
    int n;
    logic [11:0] w_reg;
    logic [11:0] h_reg;
    total = 0;
    while (total < 780) begin
      p = $urandom_range(99);
      if (p < 75) begin
        w_reg = 12'($urandom_range(1, 12) * 2);
        h_reg = 12'($urandom_range(1, 4) * 2);
      end else if (p < 85) begin
        w_reg = 12'($urandom_range(0, 31));
        h_reg = 12'($urandom_range(0, 9));
      end else if (p < 93) begin
        w_reg = 12'($urandom_range(16, 200) * 2);
        h_reg = 12'd2;
      end else begin
        w_reg = 12'($urandom_range(4095));
        h_reg = 12'($urandom_range(4095));
      end
      which = $urandom_range(3);
      if (which == 0 || which == 1) write_reg(r2i_pkg::REG_FRAME_WIDTH, w_reg);
      if (which == 0 || which == 2) write_reg(r2i_pkg::REG_FRAME_HEIGHT, h_reg);
      frame = eff_width(pred_width) * eff_height(pred_height);
      if (frame > 1000) begin
        n = $urandom_range(1, 300);
      end else if ($urandom_range(99) < 85) begin
        n = frame * $urandom_range(1, 2);
      end else begin
        n = $urandom_range(1, frame);
      end
      if ($urandom_range(19) == 0) hold_len = $urandom_range(20, 80);
      send_random_pixels(n);
      total += n;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      if (errors < 40) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : check_results
    yuv_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_yuv.size() == 0) begin
        errors++;
        if (errors < 40) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_tdata);
        end
      end else begin
        want = expected_yuv.pop_front();
        check_field("luma", want.luma, out_tdata[7:0]);
        check_field("chroma_u", want.chroma_u, out_tdata[15:8]);
        check_field("chroma_v", want.chroma_v, out_tdata[23:16]);
        check_field("chroma_valid", want.chroma_valid, out_tuser[0]);
        check_field("frame_end", want.frame_end, out_tlast);
      end
    end
  end

  always @(posedge clk) begin
    if (hold_len > 0) begin
      out_tready <= 1'b0;
      hold_len = hold_len - 1;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 7);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    errors      = 0;
    hold_len    = 0;
    steady      = 1'b0;
    cycle_count = 0;
    pred_width  = 12'd640;
    pred_height = 12'd480;
    left_px     = '0;
    col_pos     = 0;
    row_pos     = 0;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    out_tready <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_index  <= r2i_pkg::REG_FRAME_WIDTH;
    cfg_wdata  <= '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_size();
    test_colors();
    test_size_rounding();
    test_restart();
    test_line_extremes();
    test_backpressure();
    test_steady_stream();
    test_random_frames();

    wait_drain();
    repeat (8) @(posedge clk);
    if (errors == 0 && expected_yuv.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
